// ===== sv/pa_pkg.sv =====
// ----------------------------------------------------------------------------
// Primitive assembler package
// Shared types and codes for the front end, the job queue and the back end.
// ----------------------------------------------------------------------------
package pa_pkg;

   localparam int PA_QUEUE_DEPTH = 2;

   localparam logic [1:0] REQ_BEGIN  = 2'd0;
   localparam logic [1:0] REQ_VERTEX = 2'd1;
   localparam logic [1:0] REQ_END    = 2'd2;
   localparam logic [1:0] REQ_FRAME  = 2'd3;

   localparam logic [3:0] MODE_NONE   = 4'd0;
   localparam logic [3:0] MODE_POINTS = 4'd1;
   localparam logic [3:0] MODE_LINES  = 4'd2;
   localparam logic [3:0] MODE_STRIP  = 4'd3;
   localparam logic [3:0] MODE_LOOP   = 4'd4;
   localparam logic [3:0] MODE_TRIS   = 4'd5;
   localparam logic [3:0] MODE_FAN    = 4'd6;
   localparam logic [3:0] MODE_TSTRIP = 4'd7;
   localparam logic [3:0] MODE_QUADS  = 4'd8;

   localparam logic [1:0] KIND_POINT = 2'd0;
   localparam logic [1:0] KIND_SEG   = 2'd1;
   localparam logic [1:0] KIND_TRI   = 2'd2;

   localparam logic [7:0] MESH_MAX = 8'd255;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [3:0]  prim_mode;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [31:0] tex_u;
      logic [31:0] tex_v;
      logic [31:0] color_rgba;
   } pa_req_type;

   typedef struct packed {
      logic [1:0]  prim_kind;
      logic [1:0]  vertex_slot;
      logic [31:0] out_x;
      logic [31:0] out_y;
      logic [31:0] out_z;
      logic [31:0] out_u;
      logic [31:0] out_v;
      logic [31:0] out_color;
      logic [7:0]  mesh_index;
      logic        last;
   } pa_rsp_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [31:0] u;
      logic [31:0] v;
      logic [31:0] c;
   } pa_vtx_type;

   // One job describes every result that a single request causes.
   typedef struct packed {
      logic [1:0]           kind;
      logic                 quad;
      logic [2:0]           count;
      logic [7:0]           mesh;
      pa_vtx_type [3:0]     verts;
   } pa_job_type;

endpackage

// ===== sv/pa_front.sv =====
// ----------------------------------------------------------------------------
// Primitive assembler front end
// Accepts requests, tracks the open primitive and its held vertices, and
// turns each request that produces output into one job.
// ----------------------------------------------------------------------------
module pa_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pa_pkg::pa_req_type req_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_data,
   output logic               job_valid,
   output pa_pkg::pa_job_type job_data,
   input  logic               job_full
);
   import pa_pkg::*;

   logic            single_mesh_ff;
   logic [3:0]      mode_ff, mode_in;
   logic [1:0]      held_ff, held_in;
   logic            toggle_ff, toggle_in;
   logic [7:0]      mesh_ff, mesh_in;
   pa_vtx_type      slot_ff [3];
   pa_vtx_type      slot_in [3];
   pa_vtx_type      first_ff, first_in;
   pa_vtx_type      nv;
   logic            accept;

   assign req_ready = !job_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   assign nv.x = req_data.pos_x;
   assign nv.y = req_data.pos_y;
   assign nv.z = req_data.pos_z;
   assign nv.u = req_data.tex_u;
   assign nv.v = req_data.tex_v;
   assign nv.c = req_data.color_rgba;

   always_comb begin
      mode_in   = mode_ff;
      held_in   = held_ff;
      toggle_in = toggle_ff;
      mesh_in   = mesh_ff;
      slot_in   = slot_ff;
      first_in  = first_ff;
      job_valid = 1'b0;
      job_data  = '0;
      job_data.mesh = mesh_ff;
      case (req_data.req_type)
         REQ_BEGIN: begin
            mode_in   = (req_data.prim_mode <= MODE_QUADS) ? req_data.prim_mode : MODE_NONE;
            held_in   = 2'd0;
            toggle_in = 1'b1;
         end
         REQ_VERTEX: begin
            case (mode_ff)
               MODE_POINTS: begin
                  job_valid         = 1'b1;
                  job_data.kind     = KIND_POINT;
                  job_data.count    = 3'd1;
                  job_data.verts[0] = nv;
               end
               MODE_LINES, MODE_STRIP, MODE_LOOP: begin
                  if (held_ff == 2'd0) begin
                     slot_in[0] = nv;
                     if (mode_ff == MODE_LOOP) begin
                        first_in = nv;
                     end
                     held_in = 2'd1;
                  end else begin
                     job_valid         = 1'b1;
                     job_data.kind     = KIND_SEG;
                     job_data.count    = 3'd2;
                     job_data.verts[0] = slot_ff[0];
                     job_data.verts[1] = nv;
                     if (mode_ff == MODE_LINES) begin
                        held_in = 2'd0;
                     end else begin
                        slot_in[0] = nv;
                        held_in    = (mode_ff == MODE_LOOP) ? 2'd2 : 2'd1;
                     end
                  end
               end
               MODE_TRIS, MODE_FAN, MODE_TSTRIP: begin
                  if (held_ff < 2'd2) begin
                     slot_in[held_ff] = nv;
                     held_in          = held_ff + 2'd1;
                  end else begin
                     job_valid         = 1'b1;
                     job_data.kind     = KIND_TRI;
                     job_data.count    = 3'd3;
                     job_data.verts[0] = slot_ff[0];
                     job_data.verts[1] = slot_ff[1];
                     job_data.verts[2] = nv;
                     if (mode_ff == MODE_TRIS) begin
                        held_in = 2'd0;
                     end else if (mode_ff == MODE_FAN) begin
                        slot_in[1] = nv;
                     end else if (toggle_ff) begin
                        slot_in[0] = nv;
                        toggle_in  = 1'b0;
                     end else begin
                        slot_in[1] = nv;
                        toggle_in  = 1'b1;
                     end
                  end
               end
               MODE_QUADS: begin
                  if (held_ff < 2'd3) begin
                     slot_in[held_ff] = nv;
                     held_in          = held_ff + 2'd1;
                  end else begin
                     job_valid         = 1'b1;
                     job_data.kind     = KIND_TRI;
                     job_data.quad     = 1'b1;
                     job_data.count    = 3'd6;
                     job_data.verts[0] = slot_ff[0];
                     job_data.verts[1] = slot_ff[1];
                     job_data.verts[2] = slot_ff[2];
                     job_data.verts[3] = nv;
                     held_in           = 2'd0;
                  end
               end
               default: begin
               end
            endcase
         end
         REQ_END: begin
            if (mode_ff == MODE_LOOP && held_ff == 2'd2 &&
                (slot_ff[0].x != first_ff.x || slot_ff[0].y != first_ff.y ||
                 slot_ff[0].z != first_ff.z)) begin
               job_valid         = 1'b1;
               job_data.kind     = KIND_SEG;
               job_data.count    = 3'd2;
               job_data.verts[0] = slot_ff[0];
               job_data.verts[1] = first_ff;
            end
            if (!single_mesh_ff && mesh_ff != MESH_MAX) begin
               mesh_in = mesh_ff + 8'd1;
            end
            mode_in   = MODE_NONE;
            held_in   = 2'd0;
            toggle_in = 1'b1;
         end
         default: begin
            mesh_in   = 8'd0;
            mode_in   = MODE_NONE;
            held_in   = 2'd0;
            toggle_in = 1'b1;
         end
      endcase
      if (!accept) begin
         job_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         single_mesh_ff <= 1'b0;
         mode_ff        <= MODE_NONE;
         held_ff        <= 2'd0;
         toggle_ff      <= 1'b1;
         mesh_ff        <= 8'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            single_mesh_ff <= csr_data;
         end
         if (accept) begin
            mode_ff   <= mode_in;
            held_ff   <= held_in;
            toggle_ff <= toggle_in;
            mesh_ff   <= mesh_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff  <= slot_in;
         first_ff <= first_in;
      end
   end

endmodule

// ===== sv/pa_queue.sv =====
// ----------------------------------------------------------------------------
// Primitive assembler job queue
// A short first-in first-out buffer that decouples the front end from the
// back end.
// ----------------------------------------------------------------------------
module pa_queue #(
   parameter int DEPTH = pa_pkg::PA_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pa_pkg::pa_job_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output pa_pkg::pa_job_type head_data
);
   import pa_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   pa_job_type       entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/pa_back.sv =====
// ----------------------------------------------------------------------------
// Primitive assembler back end
// Takes one job at a time from the queue and sends its vertex results, one
// per cycle unless rsp_ready stalls them, through a registered output stage.
// ----------------------------------------------------------------------------
module pa_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  pa_pkg::pa_job_type head_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pa_pkg::pa_rsp_type rsp_data
);
   import pa_pkg::*;

   pa_job_type  job_ff;
   logic        busy_ff;
   logic [2:0]  step_ff;
   logic        rsp_valid_ff;
   pa_rsp_type  rsp_ff, rsp_in;
   logic        out_free, emit, is_last;
   logic [1:0]  vidx;
   logic [1:0]  slot;
   pa_vtx_type  vsel;

   // A quad is emitted as triangles (0,1,2) and (0,2,3).
   function automatic logic [1:0] quad_index(input logic [2:0] step);
      logic [1:0] idx;
      case (step)
         3'd0:    idx = 2'd0;
         3'd1:    idx = 2'd1;
         3'd2:    idx = 2'd2;
         3'd3:    idx = 2'd0;
         3'd4:    idx = 2'd2;
         default: idx = 2'd3;
      endcase
      return idx;
   endfunction

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = busy_ff && out_free;
   assign is_last  = ((step_ff + 3'd1) == job_ff.count);
   assign pop      = head_valid && (!busy_ff || (emit && is_last));
   assign vidx     = job_ff.quad ? quad_index(step_ff) : step_ff[1:0];
   assign slot     = (step_ff >= 3'd3) ? 2'(step_ff - 3'd3) : step_ff[1:0];
   assign vsel     = job_ff.verts[vidx];

   always_comb begin
      rsp_in.prim_kind   = job_ff.kind;
      rsp_in.vertex_slot = slot;
      rsp_in.out_x       = vsel.x;
      rsp_in.out_y       = vsel.y;
      rsp_in.out_z       = vsel.z;
      rsp_in.out_u       = vsel.u;
      rsp_in.out_v       = vsel.v;
      rsp_in.out_color   = vsel.c;
      rsp_in.mesh_index  = job_ff.mesh;
      rsp_in.last        = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            busy_ff <= 1'b1;
            step_ff <= 3'd0;
         end else if (emit && is_last) begin
            busy_ff <= 1'b0;
            step_ff <= 3'd0;
         end else if (emit) begin
            step_ff <= step_ff + 3'd1;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= head_data;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/primitive_assembler_unit.sv =====
// ----------------------------------------------------------------------------
// Primitive assembler unit
// Immediate-mode primitive assembly: turns begin, vertex, end and frame
// reset requests into points, segments and triangles, one vertex per result.
//
//   Channel   Ports                        Carries
//   request   req_valid/req_ready/req_data begin, vertex, end, frame reset
//   result    rsp_valid/rsp_ready/rsp_data one vertex of a primitive
//   control   csr_valid/csr_ready/csr_data single mesh flag
//
// A request is taken every cycle while the job queue has room; its results
// leave one per cycle while rsp_ready allows, and a request has from one to
// six results (three for a triangle) or none. The back end's output stage
// sets that rate. Reset is synchronous and clears all control state; no
// clearing pass follows it. A stalled result side fills the queue and then
// holds requests.
// ----------------------------------------------------------------------------
module primitive_assembler_unit #(
   parameter int QUEUE_DEPTH = pa_pkg::PA_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pa_pkg::pa_req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pa_pkg::pa_rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_data
);
   import pa_pkg::*;

   logic       job_valid, job_full, head_valid, pop;
   pa_job_type job_data, head_data;

   pa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_full  (job_full)
   );

   pa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_valid),
      .push_data  (job_data),
      .full       (job_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   pa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== tb/sv/primitive_assembler_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Primitive assembler unit testbench
// Sends begin, vertex, end and frame reset requests and checks every vertex
// result against a predictor of the mode-based assembly and the mesh index.
// Fixed sequences cover the special cases. Random primitives with random
// vertex data follow. Both sides idle at random, and the result side is held
// off long enough to fill the block.
// ----------------------------------------------------------------------------
module primitive_assembler_unit_tb;
   import pa_pkg::*;

   localparam int RESET_CYCLES   = 8;
   localparam int DRAIN_CYCLES   = 20;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int REPORT_LIMIT   = 100;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   pa_req_type req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   pa_rsp_type rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_data = 1'b0;

   pa_req_type pending_requests[$];
   pa_rsp_type expected_vertices[$];

   int req_idle_pct    = 20;
   int rsp_idle_pct    = 20;
   int holdoff_request = 0;
   int holdoff_left    = 0;
   int idle_cycles     = 0;
   int failure_count   = 0;
   int result_count    = 0;
   int queued_count    = 0;

   // Predictor state.
   logic       single_mesh_cfg = 1'b0;
   logic [3:0] asm_mode = MODE_NONE;
   int         held_count = 0;
   logic       strip_toggle = 1'b1;
   pa_vtx_type held_vtx[3];
   pa_vtx_type loop_anchor;
   logic [7:0] mesh_count = 8'd0;

   primitive_assembler_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_failure(input string msg);
      if (failure_count < REPORT_LIMIT) begin
         $display("MISMATCH: %s", msg);
      end
      failure_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         report_failure($sformatf("result %0d %s got %h expected %h",
                                  result_count, name, got, want));
      end
   endtask

   task automatic expect_vertex(input logic [1:0] kind, input logic [1:0] slot,
                                input pa_vtx_type v);
      pa_rsp_type r;
      r.prim_kind   = kind;
      r.vertex_slot = slot;
      r.out_x       = v.x;
      r.out_y       = v.y;
      r.out_z       = v.z;
      r.out_u       = v.u;
      r.out_v       = v.v;
      r.out_color   = v.c;
      r.mesh_index  = mesh_count;
      r.last        = 1'b0;
      expected_vertices.insert(expected_vertices.size(), r);
   endtask

   task automatic expect_triangle(input pa_vtx_type a, input pa_vtx_type b,
                                  input pa_vtx_type c);
      expect_vertex(KIND_TRI, 2'd0, a);
      expect_vertex(KIND_TRI, 2'd1, b);
      expect_vertex(KIND_TRI, 2'd2, c);
   endtask

   task automatic assemble_request(input pa_req_type r);
      pa_vtx_type nv;
      pa_rsp_type tail;
      int         base;
      base = expected_vertices.size();
      nv.x = r.pos_x;
      nv.y = r.pos_y;
      nv.z = r.pos_z;
      nv.u = r.tex_u;
      nv.v = r.tex_v;
      nv.c = r.color_rgba;
      case (r.req_type)
         REQ_BEGIN: begin
            asm_mode     = (r.prim_mode <= MODE_QUADS) ? r.prim_mode : MODE_NONE;
            held_count   = 0;
            strip_toggle = 1'b1;
         end
         REQ_VERTEX: begin
            case (asm_mode)
               MODE_POINTS: begin
                  expect_vertex(KIND_POINT, 2'd0, nv);
               end
               MODE_LINES, MODE_STRIP, MODE_LOOP: begin
                  if (held_count == 0) begin
                     held_vtx[0] = nv;
                     if (asm_mode == MODE_LOOP) begin
                        loop_anchor = nv;
                     end
                     held_count = 1;
                  end else begin
                     expect_vertex(KIND_SEG, 2'd0, held_vtx[0]);
                     expect_vertex(KIND_SEG, 2'd1, nv);
                     if (asm_mode == MODE_LINES) begin
                        held_count = 0;
                     end else begin
                        held_vtx[0] = nv;
                        held_count  = (asm_mode == MODE_LOOP) ? 2 : 1;
                     end
                  end
               end
               MODE_TRIS, MODE_FAN, MODE_TSTRIP: begin
                  if (held_count < 2) begin
                     held_vtx[held_count] = nv;
                     held_count++;
                  end else begin
                     expect_triangle(held_vtx[0], held_vtx[1], nv);
                     if (asm_mode == MODE_TRIS) begin
                        held_count = 0;
                     end else if (asm_mode == MODE_FAN) begin
                        held_vtx[1] = nv;
                     end else if (strip_toggle) begin
                        held_vtx[0]  = nv;
                        strip_toggle = 1'b0;
                     end else begin
                        held_vtx[1]  = nv;
                        strip_toggle = 1'b1;
                     end
                  end
               end
               MODE_QUADS: begin
                  if (held_count < 3) begin
                     held_vtx[held_count] = nv;
                     held_count++;
                  end else begin
                     expect_triangle(held_vtx[0], held_vtx[1], held_vtx[2]);
                     expect_triangle(held_vtx[0], held_vtx[2], nv);
                     held_count = 0;
                  end
               end
               default: begin
               end
            endcase
         end
         REQ_END: begin
            if (asm_mode == MODE_LOOP && held_count == 2 &&
                {held_vtx[0].x, held_vtx[0].y, held_vtx[0].z} !=
                {loop_anchor.x, loop_anchor.y, loop_anchor.z}) begin
               expect_vertex(KIND_SEG, 2'd0, held_vtx[0]);
               expect_vertex(KIND_SEG, 2'd1, loop_anchor);
            end
            if (!single_mesh_cfg && mesh_count != MESH_MAX) begin
               mesh_count++;
            end
            asm_mode     = MODE_NONE;
            held_count   = 0;
            strip_toggle = 1'b1;
         end
         default: begin
            mesh_count   = 8'd0;
            asm_mode     = MODE_NONE;
            held_count   = 0;
            strip_toggle = 1'b1;
         end
      endcase
      if (expected_vertices.size() > base) begin
         tail = expected_vertices[expected_vertices.size() - 1];
         tail.last = 1'b1;
         expected_vertices[expected_vertices.size() - 1] = tail;
      end
   endtask

   task automatic check_vertex(input pa_rsp_type got);
      pa_rsp_type want;
      if (expected_vertices.size() == 0) begin
         report_failure($sformatf("result %0d arrived with none expected, x %h",
                                  result_count, got.out_x));
      end else begin
         want = expected_vertices.pop_front();
         compare_field("prim_kind", {30'd0, got.prim_kind}, {30'd0, want.prim_kind});
         compare_field("vertex_slot", {30'd0, got.vertex_slot},
                       {30'd0, want.vertex_slot});
         compare_field("out_x", got.out_x, want.out_x);
         compare_field("out_y", got.out_y, want.out_y);
         compare_field("out_z", got.out_z, want.out_z);
         compare_field("out_u", got.out_u, want.out_u);
         compare_field("out_v", got.out_v, want.out_v);
         compare_field("out_color", got.out_color, want.out_color);
         compare_field("mesh_index", {24'd0, got.mesh_index}, {24'd0, want.mesh_index});
         compare_field("last", {31'd0, got.last}, {31'd0, want.last});
      end
      result_count++;
   endtask

   function automatic pa_vtx_type random_vertex();
      pa_vtx_type v;
      v.x = $urandom;
      v.y = $urandom;
      v.z = $urandom;
      v.u = $urandom;
      v.v = $urandom;
      v.c = $urandom;
      return v;
   endfunction

   task automatic queue_request(input logic [1:0] kind, input logic [3:0] mode,
                                input pa_vtx_type v);
      pa_req_type r;
      r.req_type   = kind;
      r.prim_mode  = mode;
      r.pos_x      = v.x;
      r.pos_y      = v.y;
      r.pos_z      = v.z;
      r.tex_u      = v.u;
      r.tex_v      = v.v;
      r.color_rgba = v.c;
      pending_requests.insert(pending_requests.size(), r);
      queued_count++;
   endtask

   task automatic queue_random_primitive();
      int          pick;
      int          verts;
      int          mode_pick;
      logic [3:0]  mode;
      pa_vtx_type  v;
      pa_vtx_type  first;
      pick      = $urandom_range(0, 99);
      mode_pick = $urandom_range(0, 15);
      first     = random_vertex();
      if (pick < 10) begin
         case ($urandom_range(0, 3))
            0: queue_request(REQ_VERTEX, mode_pick[3:0], random_vertex());
            1: queue_request(REQ_END, mode_pick[3:0], random_vertex());
            2: queue_request(REQ_FRAME, mode_pick[3:0], random_vertex());
            default: begin
               mode_pick = $urandom_range(9, 15);
               queue_request(REQ_BEGIN, mode_pick[3:0], random_vertex());
               queue_request(REQ_VERTEX, MODE_NONE, random_vertex());
            end
         endcase
      end else begin
         if (pick >= 14) begin
            mode_pick = $urandom_range(1, 8);
         end
         mode = mode_pick[3:0];
         queue_request(REQ_BEGIN, mode, random_vertex());
         verts = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 9);
         for (int i = 0; i < verts; i++) begin
            v = random_vertex();
            if (i == 0) begin
               first = v;
            end else if (mode == MODE_LOOP && i == verts - 1 && $urandom_range(0, 2) == 0) begin
               v.x = first.x;
               v.y = first.y;
               v.z = first.z;
            end
            queue_request(REQ_VERTEX, mode, v);
         end
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            queue_request(REQ_END, mode, random_vertex());
         end else if (pick < 93) begin
            queue_request(REQ_FRAME, mode, random_vertex());
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || expected_vertices.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_single_mesh(input logic value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_requests.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
            req_data  <= pending_requests.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (holdoff_request != 0) begin
            holdoff_left    = holdoff_request;
            holdoff_request = 0;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            single_mesh_cfg = csr_data;
         end
         if (req_valid && req_ready) begin
            assemble_request(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            check_vertex(rsp_data);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      pa_vtx_type va;
      pa_vtx_type vb;
      pa_vtx_type vc;
      pa_vtx_type vd;
      pa_vtx_type ones;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      write_single_mesh(1'b0);

      // Field extremes, restarts, both outcomes of loop closing, stray requests.
      ones = '1;
      va = random_vertex();
      vb = random_vertex();
      vc = random_vertex();
      vd = random_vertex();
      queue_request(REQ_BEGIN, MODE_POINTS, '0);
      queue_request(REQ_VERTEX, MODE_NONE, '0);
      queue_request(REQ_VERTEX, 4'hF, ones);
      queue_request(REQ_BEGIN, MODE_LINES, ones);
      queue_request(REQ_VERTEX, MODE_LINES, va);
      queue_request(REQ_BEGIN, MODE_LOOP, random_vertex());
      queue_request(REQ_VERTEX, MODE_LOOP, vb);
      queue_request(REQ_VERTEX, MODE_LOOP, vc);
      queue_request(REQ_VERTEX, MODE_LOOP, vd);
      queue_request(REQ_END, MODE_LOOP, random_vertex());
      queue_request(REQ_BEGIN, MODE_LOOP, random_vertex());
      queue_request(REQ_VERTEX, MODE_LOOP, vb);
      queue_request(REQ_VERTEX, MODE_LOOP, vc);
      va = random_vertex();
      va.x = vb.x;
      va.y = vb.y;
      va.z = vb.z;
      queue_request(REQ_VERTEX, MODE_LOOP, va);
      queue_request(REQ_END, MODE_LOOP, random_vertex());
      queue_request(REQ_BEGIN, MODE_LOOP, random_vertex());
      queue_request(REQ_VERTEX, MODE_LOOP, vc);
      queue_request(REQ_END, MODE_LOOP, random_vertex());
      queue_request(REQ_VERTEX, MODE_POINTS, random_vertex());
      queue_request(REQ_END, MODE_NONE, random_vertex());
      queue_request(REQ_BEGIN, 4'hF, random_vertex());
      queue_request(REQ_VERTEX, 4'hF, random_vertex());
      queue_request(REQ_FRAME, MODE_QUADS, random_vertex());
      wait_drained();

      write_single_mesh(1'b1);
      queued_count = 0;
      while (queued_count < 25) begin
         queue_random_primitive();
      end
      wait_drained();

      write_single_mesh(1'b0);
      holdoff_request = HOLDOFF_CYCLES;
      queue_request(REQ_BEGIN, MODE_TRIS, random_vertex());
      repeat (15) queue_request(REQ_VERTEX, MODE_TRIS, random_vertex());
      queue_request(REQ_END, MODE_TRIS, random_vertex());
      queued_count = 0;
      while (queued_count < 25) begin
         queue_random_primitive();
      end
      wait_drained();

      queue_request(REQ_FRAME, MODE_NONE, random_vertex());
      queue_request(REQ_BEGIN, MODE_POINTS, random_vertex());
      queue_request(REQ_VERTEX, MODE_POINTS, random_vertex());
      queue_request(REQ_END, MODE_POINTS, random_vertex());
      queue_request(REQ_BEGIN, MODE_POINTS, random_vertex());
      queue_request(REQ_VERTEX, MODE_POINTS, random_vertex());
      wait_drained();

      write_single_mesh(1'b1);
      queue_request(REQ_END, MODE_POINTS, random_vertex());
      queue_request(REQ_BEGIN, MODE_QUADS, random_vertex());
      repeat (4) queue_request(REQ_VERTEX, MODE_QUADS, random_vertex());
      queue_request(REQ_FRAME, MODE_QUADS, random_vertex());
      wait_drained();

      write_single_mesh(1'b0);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      queued_count = 0;
      while (queued_count < 20) begin
         queue_random_primitive();
      end
      wait_drained();
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      queued_count = 0;
      while (queued_count < 20) begin
         queue_random_primitive();
      end
      wait_drained();

      if (failure_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/pa_pkg.sv
sv/pa_front.sv
sv/pa_queue.sv
sv/pa_back.sv
sv/primitive_assembler_unit.sv
tb/sv/primitive_assembler_unit_tb.sv
